>>> hw/rtl/chroma_444_to_420_filter_core_defines.svh
// Assertion macros used by the checker file.
`ifndef CHROMA_444_TO_420_FILTER_CORE_DEFINES_SVH
`define CHROMA_444_TO_420_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define C420F_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c420f check failed");

// Next-cycle implication, ignored while reset is asserted.
`define C420F_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c420f check failed");

// Next-cycle implication that is checked during reset as well.
`define C420F_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("c420f reset check failed");

`endif

>>> hw/rtl/c420f_pkg.sv
`timescale 1ns / 1ps
package c420f_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

  localparam int SAMPLE_W   = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = SAMPLE_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = CFG_DATA_W'(480);

endpackage

>>> hw/rtl/chroma_444_to_420_filter_core.sv
`timescale 1ns / 1ps
// Chroma 4:4:4 to 4:2:0 subsampler.
// Input words carry one chroma sample each, in raster order. Output words
// carry one filtered value per 2x2 block, (TL + 3*TR + 3*BL + 9*BR + 8) >> 4,
// with end_of_row and end_of_frame marks. An unpaired last column or row
// gives no output, and a frame narrower or shorter than two gives none.
// Frame width and height are written through the cfg port (index 0 and 1);
// the user writes them only while the block is idle, which the block does
// not enforce; any such write restarts the frame. Throughput is one sample
// per cycle while in_stall is low. A sample on the bottom row reads the line
// store at its column at the edge that accepts it; the filter result is then
// loaded into the output register, raising out_valid, once the output is free.
// When the receiver stalls, the output register holds its word and samples
// keep entering until a bottom-right sample waits in the read stage; then
// in_stall stays high until the output drains. Reset clears the counters,
// valid flags and holds and loads the default 640 x 480 geometry; the line
// store keeps its contents, and every entry is written on a top row before
// any bottom row reads it.
module chroma_444_to_420_filter_core
  import c420f_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SAMPLE_W-1:0]   out_chroma_out,
  output logic                  out_end_of_row,
  output logic                  out_end_of_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                 input int unsigned max_v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > max_v) begin
      res = DIM_W'(max_v);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  logic [CFG_DATA_W-1:0] frame_width_r, frame_height_r;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [DIM_W-1:0]      w_eff, h_eff, last_col, last_row;
  logic                  cfg_hit;

  logic [SAMPLE_W-1:0]   line_mem [MAX_WIDTH];
  logic [SAMPLE_W-1:0]   rd_data_r;

  logic                  s1_valid_r, s1_emit_r, s1_eor_r, s1_eof_r;
  logic [SAMPLE_W-1:0]   s1_sample_r;
  logic [SAMPLE_W-1:0]   top_hold_r, bottom_hold_r;

  logic                  out_valid_r, out_eor_r, out_eof_r;
  logic [SAMPLE_W-1:0]   out_chroma_r;

  logic                  accept, out_free, s1_done;
  logic [SUM_W-1:0]      sum;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && ((cfg_index == REG_FRAME_WIDTH) ||
                                   (cfg_index == REG_FRAME_HEIGHT));

  always_comb begin
    w_eff    = clamp_dim(frame_width_r, MAX_WIDTH);
    h_eff    = clamp_dim(frame_height_r, MAX_HEIGHT);
    // Below two these wrap to all ones and never match a live counter.
    last_col = {w_eff[DIM_W-1:1], 1'b0} - DIM_W'(1);
    last_row = {h_eff[DIM_W-1:1], 1'b0} - DIM_W'(1);
  end

  // The read stage waits only when it holds a result and the output is full and stalled.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_done  = s1_valid_r && (!s1_emit_r || out_free);
  assign in_stall = s1_valid_r && !s1_done;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if ((DIM_W'(col_r) + DIM_W'(1)) >= w_eff) begin
        col_nxt = '0;
        if ((DIM_W'(row_r) + DIM_W'(1)) >= h_eff) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Top rows write, bottom rows read; one access per accepted word, and a
  // bottom row only reads entries the preceding top row wrote, so no two
  // accesses to one entry overlap.
  always_ff @(posedge clk) begin
    if (accept && !row_r[0]) begin
      line_mem[col_r] <= in_sample;
    end
    if (accept && row_r[0]) begin
      rd_data_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= row_r[0];
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_r[0]) begin
      s1_emit_r   <= col_r[0];
      s1_sample_r <= in_sample;
      s1_eor_r    <= (DIM_W'(col_r) == last_col);
      s1_eof_r    <= (DIM_W'(col_r) == last_col) && (DIM_W'(row_r) == last_row);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_hold_r    <= '0;
      bottom_hold_r <= '0;
    end else if (s1_done && !s1_emit_r) begin
      top_hold_r    <= rd_data_r;
      bottom_hold_r <= s1_sample_r;
    end
  end

  always_comb begin
    sum = SUM_W'(top_hold_r)
        + SUM_W'({rd_data_r, 1'b0}) + SUM_W'(rd_data_r)
        + SUM_W'({bottom_hold_r, 1'b0}) + SUM_W'(bottom_hold_r)
        + SUM_W'({s1_sample_r, 3'b000}) + SUM_W'(s1_sample_r)
        + SUM_W'(8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1_emit_r) begin
      out_chroma_r <= sum[SUM_W-1:4];
      out_eor_r    <= s1_eor_r;
      out_eof_r    <= s1_eof_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chroma_out   = out_chroma_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

endmodule

>>> hw/rtl/c420f_checker.sv
`timescale 1ns / 1ps
`include "chroma_444_to_420_filter_core_defines.svh"
module c420f_checker
  import c420f_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [SAMPLE_W-1:0]   out_chroma_out,
  input logic                  out_end_of_row,
  input logic                  out_end_of_frame
);

  // A stalled output word stays valid and keeps its value.
  `C420F_ASSERT_NXT(a_out_hold_valid, out_valid && out_stall, out_valid)
  `C420F_ASSERT_NXT(a_out_hold_data, out_valid && out_stall, $stable(out_chroma_out))

  // The frame ends on the last word of a row.
  `C420F_ASSERT_IMP(a_eof_is_eor, out_valid && out_end_of_frame, out_end_of_row)

  // The input is held off only behind a full, stalled output.
  `C420F_ASSERT_IMP(a_in_stall_cause, in_stall, out_valid && out_stall)

  // Reset empties the output register.
  `C420F_ASSERT_RST(a_reset_clears_out, !rst_n, !out_valid)

endmodule

bind chroma_444_to_420_filter_core c420f_checker u_c420f_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import c420f_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int GAP_MAX      = 19;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 80;

  typedef struct packed {
    logic [SAMPLE_W-1:0] chroma;
    logic                end_of_row;
    logic                end_of_frame;
  } block_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample;
  logic                  out_valid;
  logic                  out_stall;
  logic [SAMPLE_W-1:0]   out_chroma_out;
  logic                  out_end_of_row;
  logic                  out_end_of_frame;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  chroma_444_to_420_filter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chroma_out   (out_chroma_out),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the subsampler.
  logic [SAMPLE_W-1:0]   top_row [MAX_WIDTH];
  logic [SAMPLE_W-1:0]   top_left_q = '0;
  logic [SAMPLE_W-1:0]   bottom_left_q = '0;
  int                    col_pos = 0;
  int                    row_pos = 0;
  logic [CFG_DATA_W-1:0] width_reg = FRAME_WIDTH_RST;
  logic [CFG_DATA_W-1:0] height_reg = FRAME_HEIGHT_RST;
  block_word_t           expected_blocks [$];

  int failures = 0;
  int idle_cycles = 0;
  int in_gap_max = GAP_MAX;
  int out_gap_max = GAP_MAX;
  int long_hold_cycles = 0;

  function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic void predict_subsample(input logic [SAMPLE_W-1:0] s);
    int w, h, c, r;
    int unsigned acc;
    block_word_t word;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    if (r % 2 == 0) begin
      top_row[c] = s;
    end else if (c % 2 == 0) begin
      top_left_q = top_row[c];
      bottom_left_q = s;
    end else begin
      acc = int'(top_left_q) + 3 * (int'(top_row[c]) + int'(bottom_left_q))
            + 9 * int'(s) + 8;
      word.chroma = SAMPLE_W'(acc >> 4);
      // The last column of the last full column pair closes the output row.
      word.end_of_row = (c == (w & ~1) - 1);
      word.end_of_frame = word.end_of_row && (r == (h & ~1) - 1);
      expected_blocks.push_back(word);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] value);
    if (idx == REG_FRAME_WIDTH) width_reg = value;
    else if (idx == REG_FRAME_HEIGHT) height_reg = value;
    else return;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_subsample(s);
  endtask

  task automatic send_burst(input int count);
    repeat (count) send_sample(draw_sample());
  endtask

  // Also covers the cycles that a sample with no output may still spend inside.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_config(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h);
    wait_drained();
    cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  // The first row pair after reset must follow the reset width.
  task automatic test_default_geometry();
    send_burst(int'(FRAME_WIDTH_RST) + 4);
  endtask

  task automatic test_corner_blocks();
    logic [3:0] masks [6] = '{4'b0000, 4'b1111, 4'b0001, 4'b0010, 4'b0100, 4'b1000};
    set_geometry(2, 2);
    foreach (masks[m]) begin
      for (int i = 0; i < 4; i++) send_sample(masks[m][i] ? '1 : '0);
    end
  endtask

  // Degenerate and odd sizes, zero register values included.
  task automatic test_small_shapes();
    int shapes [7][3] = '{'{0, 2, 8}, '{1, 4, 8}, '{4, 0, 8}, '{4, 1, 8},
                          '{5, 3, 30}, '{3, 4, 24}, '{2, 3, 12}};
    foreach (shapes[k]) begin
      set_geometry(shapes[k][0], shapes[k][1]);
      send_burst(shapes[k][2]);
    end
  endtask

  task automatic test_register_writes();
    set_geometry(4, 4);
    send_burst(6);
    wait_drained();
    // Writes to unused indexes must not restart the frame.
    cfg_write(REG_SPARE_2, 13'd3);
    cfg_write(REG_SPARE_3, '1);
    send_burst(16);
    wait_drained();
    cfg_write(REG_FRAME_HEIGHT, 13'd4);
    send_burst(16);
  endtask

  task automatic test_backpressure();
    set_geometry(2, 16);
    in_gap_max = 0;
    out_gap_max = 0;
    long_hold_cycles = LONG_HOLD;
    send_burst(40);
    wait_drained();
    send_burst(10);
    in_gap_max = GAP_MAX;
    out_gap_max = GAP_MAX;
  endtask

  task automatic test_random_geometry();
    int odd_widths [6] = '{0, 1, 3, 7, 33, 64};
    int sent, w, h, n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) w = odd_widths[$urandom_range(0, 5)];
      else w = $urandom_range(2, 12);
      if ($urandom_range(0, 4) == 0) h = $urandom_range(0, 3);
      else h = $urandom_range(2, 8);
      wait_drained();
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      if ($urandom_range(0, 1) == 1) begin
        cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
      end else begin
        cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(w));
      end
      n = clamp_dim(CFG_DATA_W'(w), MAX_WIDTH) * clamp_dim(CFG_DATA_W'(h), MAX_HEIGHT)
          * $urandom_range(1, 3);
      if (n > 40) n = 40;
      // Now and then a frame is cut short by the next register write.
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      send_burst(n);
      sent += n;
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    in_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    foreach (top_row[i]) top_row[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_geometry();
    test_corner_blocks();
    test_small_shapes();
    test_register_writes();
    test_backpressure();
    test_random_geometry();
    wait_drained();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_check
    int gap;
    block_word_t want, got;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_cycles > 0) begin
        gap = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, out_gap_max);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {out_chroma_out, out_end_of_row, out_end_of_frame};
      if (expected_blocks.size() == 0) begin
        note_failure($sformatf("unexpected word chroma=%0d eor=%b eof=%b",
                               got.chroma, got.end_of_row, got.end_of_frame));
      end else begin
        want = expected_blocks.pop_front();
        if (got !== want)
          note_failure($sformatf("expected chroma=%0d eor=%b eof=%b, got chroma=%0d eor=%b eof=%b",
                                 want.chroma, want.end_of_row, want.end_of_frame,
                                 got.chroma, got.end_of_row, got.end_of_frame));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/c420f_pkg.sv
hw/rtl/chroma_444_to_420_filter_core.sv
hw/rtl/c420f_checker.sv
tb/testbench.sv
